>>> sv/spq_pkg.sv
// shared types and constants of the sorted priority queue
package spq_pkg;

  // default number of entries held
  localparam int unsigned CAPACITY_DEF = 16;

  // operation codes carried in the op field
  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_SEARCH  = 3'd2,
    OP_DELETE  = 3'd3,
    OP_RESCHED = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // sequencer states of the queue core
  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_EV,
    S_DEL_RD,
    S_DEL_EV,
    S_INS_RD,
    S_INS_EV,
    S_DONE
  } state_e;

  // one stored queue entry
  typedef struct packed {
    logic [31:0]        key;
    logic signed [15:0] pri;
  } entry_t;

  // one request to the queue core
  typedef struct packed {
    logic [2:0]         op;
    logic [31:0]        key;
    logic signed [15:0] pri;
  } req_t;

  // one response of the queue core, count travels beside it
  typedef struct packed {
    status_e            status;
    logic [31:0]        key;
    logic signed [15:0] pri;
  } rsp_t;

endpackage

>>> sv/spq_core.sv
// sequencer and entry memory of the sorted priority queue
module spq_core #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  spq_pkg::req_t     req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output spq_pkg::rsp_t     rsp_o,
  output logic [CntW-1:0]   count_o
);
  import spq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  // entry memory, head at address zero
  entry_t mem [CAPACITY];

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   idx_q, idx_d;
  status_e           stat_q, stat_d;
  logic [31:0]       fkey_q, fkey_d;
  logic signed [15:0] fpri_q, fpri_d;
  entry_t            rdata_q;

  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;

  logic [CntW-1:0]   idx_inc;
  logic [CntW-1:0]   idx_dec;
  logic [CntW-1:0]   cnt_dec;
  logic              key_match;
  logic [31:0]       ins_key;

  assign idx_inc   = idx_q + CntW'(1);
  assign idx_dec   = idx_q - CntW'(1);
  assign cnt_dec   = cnt_q - CntW'(1);
  assign key_match = (req_q.op == OP_POP) || (rdata_q.key == req_q.key);
  assign ins_key   = (req_q.op == OP_PUSH) ? req_q.key : fkey_q;

  // memory write port and registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    stat_q <= stat_d;
    fkey_q <= fkey_d;
    fpri_q <= fpri_d;
  end

  // sequencer: scan, shift out and shift in one entry at a time, each as a read state then an evaluate state
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    stat_d    = stat_q;
    fkey_d    = fkey_q;
    fpri_d    = fpri_q;
    mem_re    = 1'b0;
    mem_raddr = idx_q[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = rdata_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d  = req_i;
          stat_d = STAT_OK;
          fkey_d = '0;
          fpri_d = '0;
          case (req_i.op)
            OP_PUSH: begin
              if (cnt_q == CntW'(CAPACITY)) begin
                stat_d  = STAT_FULL;
                state_d = S_DONE;
              end else begin
                idx_d   = cnt_q;
                state_d = S_INS_RD;
              end
            end
            OP_POP, OP_SEARCH, OP_DELETE, OP_RESCHED: begin
              if (cnt_q == '0) begin
                stat_d  = STAT_EMPTY;
                state_d = S_DONE;
              end else begin
                idx_d   = '0;
                state_d = S_SRCH_RD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      // look for the first match in queue order
      S_SRCH_RD: begin
        mem_re  = 1'b1;
        state_d = S_SRCH_EV;
      end
      S_SRCH_EV: begin
        if (key_match) begin
          fkey_d = rdata_q.key;
          fpri_d = rdata_q.pri;
          if (req_q.op == OP_SEARCH) begin
            state_d = S_DONE;
          end else begin
            state_d = S_DEL_RD;
          end
        end else if (idx_inc == cnt_q) begin
          stat_d  = STAT_NOT_FOUND;
          state_d = S_DONE;
        end else begin
          idx_d   = idx_inc;
          state_d = S_SRCH_RD;
        end
      end
      // close the gap by moving later entries one place up
      S_DEL_RD: begin
        if (idx_inc < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[AW-1:0];
          state_d   = S_DEL_EV;
        end else begin
          cnt_d = cnt_dec;
          if (req_q.op == OP_RESCHED) begin
            idx_d   = cnt_dec;
            state_d = S_INS_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DEL_EV: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
        idx_d     = idx_inc;
        state_d   = S_DEL_RD;
      end
      // open a hole from the tail until the new entry fits
      S_INS_RD: begin
        if (idx_q == '0) begin
          mem_we        = 1'b1;
          mem_wdata.key = ins_key;
          mem_wdata.pri = req_q.pri;
          cnt_d         = cnt_q + CntW'(1);
          state_d       = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
          state_d   = S_INS_EV;
        end
      end
      S_INS_EV: begin
        mem_we = 1'b1;
        if ($signed(rdata_q.pri) <= $signed(req_q.pri)) begin
          mem_wdata.key = ins_key;
          mem_wdata.pri = req_q.pri;
          cnt_d         = cnt_q + CntW'(1);
          state_d       = S_DONE;
        end else begin
          mem_wdata = rdata_q;
          idx_d     = idx_dec;
          state_d   = S_INS_RD;
        end
      end
      S_DONE: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign req_ready_o  = (state_q == S_IDLE);
  assign rsp_valid_o  = (state_q == S_DONE);
  assign rsp_o.status = stat_q;
  assign rsp_o.key    = fkey_q;
  assign rsp_o.pri    = fpri_q;
  assign count_o      = cnt_q;

endmodule

>>> sv/sorted_priority_queue_unit.sv
// top level of the sorted priority queue with stream ports
// The queue keeps up to CAPACITY tasks in one single-port-write, registered-read
// memory sorted by ascending priority, equal priorities in arrival order. One
// operation is handled at a time and each yields one result transaction. A
// sequencer touches one entry at a time (memory read, then compare and
// write back): a push walks from the tail to its slot, search scans from the
// head to the first matching key, delete adds the shift of the entries behind
// the hit, and reschedule adds a push. An output register holds a finished
// result, so the next transaction can start while the previous result waits
// downstream.
module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF,
  localparam int unsigned CntW = $clog2(CAPACITY + 1),
  localparam int unsigned OutW = ((50 + CntW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // op [2:0], task_key [34:3], priority_req [50:35]
  input  logic [55:0]     s_axis_tdata_i,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // status [1:0], found_key [33:2], found_priority [49:34], entry_count [50+:CntW]
  output logic [OutW-1:0] m_axis_tdata_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i
);
  import spq_pkg::*;

  req_t            req;
  rsp_t            rsp;
  logic            rsp_valid;
  logic            out_free;
  logic [CntW-1:0] count;

  logic            out_vld_q, out_vld_d;
  rsp_t            out_rsp_q;
  logic [CntW-1:0] out_cnt_q;

  // unpack the input transaction
  assign req.op  = s_axis_tdata_i[2:0];
  assign req.key = s_axis_tdata_i[34:3];
  assign req.pri = s_axis_tdata_i[50:35];

  spq_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (out_free),
    .rsp_o       (rsp),
    .count_o     (count)
  );

  // output register
  assign out_free = !out_vld_q || m_axis_tready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (rsp_valid && out_free) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && out_free) begin
      out_rsp_q <= rsp;
      out_cnt_q <= count;
    end
  end

  // pack the output transaction
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutW - 50 - CntW){1'b0}}, out_cnt_q,
                            out_rsp_q.pri, out_rsp_q.key, out_rsp_q.status};

  // held count never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // a full status is only reported with a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_rsp_q.status == STAT_FULL) |-> (out_cnt_q == CntW'(CAPACITY)))
    else $error("full status with room left");

  // an empty status reports no entry and an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_rsp_q.status == STAT_EMPTY) |->
      (out_cnt_q == '0 && out_rsp_q.key == '0 && out_rsp_q.pri == '0))
    else $error("empty status with entries or data");

  // the count never jumps by more than one at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count != $past(count)) |->
      (count == $past(count) + CntW'(1) || count == $past(count) - CntW'(1)))
    else $error("entry count jumped");

endmodule
